// ===== rtl/tla_pkg.sv =====
// Package for the terminal line assembler: sizes, byte codes, command and
// result codes, and the state encoding of the back end. No dependencies.
package tla_pkg;

  localparam int MAX_LINE = 32;
  localparam int IDX_W = $clog2(MAX_LINE);
  localparam int CNT_W = 6;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST  = 8'h7E;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    CMD_ARM,
    CMD_PRINT,
    CMD_ERASE,
    CMD_CR,
    CMD_OTHER
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] limit;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_READ,
    ST_SEND
  } back_state_t;

endpackage

// ===== rtl/tla_in_if.sv =====
// Input channel of the line assembler: valid/ready with op, data, limit.
// Depends on nothing.
interface tla_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data;
  logic [7:0] limit;

  modport source (output valid, output op, output data, output limit, input ready);
  modport sink   (input valid, input op, input data, input limit, output ready);
endinterface

// ===== rtl/tla_out_if.sv =====
// Result channel of the line assembler: valid/ready with kind, byte, length
// and last flag. Depends on nothing.
interface tla_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_res;
  logic [5:0] length;
  logic       last;

  modport source (output valid, output kind, output data_res, output length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_res, input length,
                  input last, output ready);
endinterface

// ===== rtl/tla_front.sv =====
// Front end: accepts input transactions, classifies bytes, clips the read
// limit and drops empty read requests. Depends on tla_pkg and tla_in_if.
module tla_front (
  tla_in_if.sink        req,
  input  logic          full,
  output logic          push,
  output tla_pkg::cmd_t push_cmd
);

  logic drop;

  assign req.ready = !full;

  always_comb begin
    push_cmd.data = req.data;
    if (req.limit > 8'(tla_pkg::MAX_LINE)) begin
      push_cmd.limit = tla_pkg::CNT_W'(tla_pkg::MAX_LINE);
    end else begin
      push_cmd.limit = req.limit[tla_pkg::CNT_W-1:0];
    end
    drop = 1'b0;
    if (req.op == tla_pkg::OP_READ) begin
      push_cmd.kind = tla_pkg::CMD_ARM;
      drop = (req.limit == 8'd0);
    end else if (req.data == tla_pkg::CH_CR) begin
      push_cmd.kind = tla_pkg::CMD_CR;
    end else if (req.data == tla_pkg::CH_BS || req.data == tla_pkg::CH_DEL) begin
      push_cmd.kind = tla_pkg::CMD_ERASE;
    end else if (req.data >= tla_pkg::CH_FIRST && req.data <= tla_pkg::CH_LAST) begin
      push_cmd.kind = tla_pkg::CMD_PRINT;
    end else begin
      push_cmd.kind = tla_pkg::CMD_OTHER;
    end
  end

  // a zero-limit read request is accepted and dropped here
  assign push = req.valid && !full && !drop;

endmodule

// ===== rtl/tla_fifo.sv =====
// Short command queue between front and back end.
// Depends on tla_pkg.
module tla_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tla_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output tla_pkg::cmd_t head
);

  tla_pkg::cmd_t            slots [tla_pkg::Q_DEPTH];
  logic [tla_pkg::Q_AW-1:0] wr_ptr;
  logic [tla_pkg::Q_AW-1:0] rd_ptr;
  logic [tla_pkg::Q_AW:0]   count;

  function automatic logic [tla_pkg::Q_AW-1:0] bump(input logic [tla_pkg::Q_AW-1:0] p);
    if (p == tla_pkg::Q_AW'(tla_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full     = (count == (tla_pkg::Q_AW + 1)'(tla_pkg::Q_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop && nonempty) begin
        rd_ptr <= bump(rd_ptr);
      end
      unique case ({push && !full, pop && nonempty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tla_back.sv =====
// Back end: applies commands to the line state, writes the line store and
// drives the result register, walking the store on line completion.
// Depends on tla_pkg and tla_out_if.
module tla_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tla_pkg::cmd_t q_cmd,
  output logic          pop,
  tla_out_if.source     rsp
);

  localparam logic [tla_pkg::CNT_W-1:0] MAX_CNT = tla_pkg::CNT_W'(tla_pkg::MAX_LINE);

  tla_pkg::back_state_t state;
  tla_pkg::back_state_t state_next;

  logic [7:0]               store [tla_pkg::MAX_LINE];
  logic [7:0]               rd_data;
  logic                     armed;
  logic [tla_pkg::CNT_W-1:0] fill_count;
  logic [tla_pkg::CNT_W-1:0] line_limit;
  logic [tla_pkg::CNT_W-1:0] line_len;
  logic [tla_pkg::CNT_W-1:0] rd_ptr;

  logic                     out_valid;
  logic [1:0]               out_kind;
  logic [7:0]               out_data;
  logic [tla_pkg::CNT_W-1:0] out_length;
  logic                     out_last;

  logic                     out_free;
  logic                     is_byte;
  logic                     done;
  logic                     store_en;
  logic [7:0]               wr_data;
  logic [tla_pkg::CNT_W-1:0] fill_next;
  logic                     line_last;
  logic                     load_echo;
  logic                     load_empty;
  logic                     load_line;
  logic                     rd_en;

  assign out_free  = !out_valid || rsp.ready;
  assign is_byte   = (q_cmd.kind != tla_pkg::CMD_ARM);
  assign line_last = (tla_pkg::CNT_W'(rd_ptr + 1'b1) == line_len);

  // effect of the head command on the line
  always_comb begin
    done      = 1'b0;
    store_en  = 1'b0;
    wr_data   = q_cmd.data;
    fill_next = fill_count;
    if (armed) begin
      unique case (q_cmd.kind)
        tla_pkg::CMD_CR: begin
          wr_data = tla_pkg::CH_LF;
          done    = 1'b1;
          if (fill_count < MAX_CNT) begin
            store_en  = 1'b1;
            fill_next = fill_count + 1'b1;
          end
        end
        tla_pkg::CMD_ERASE: begin
          if (fill_count != '0) begin
            fill_next = fill_count - 1'b1;
          end
        end
        tla_pkg::CMD_PRINT: begin
          if (fill_count < MAX_CNT) begin
            store_en  = 1'b1;
            fill_next = fill_count + 1'b1;
            done      = (fill_next >= line_limit);
          end else begin
            done = 1'b1;
          end
        end
        tla_pkg::CMD_OTHER: done = 1'b1;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tla_pkg::ST_IDLE: begin
        if (q_valid && is_byte && out_free && done) begin
          state_next = (fill_next == '0) ? tla_pkg::ST_EMPTY : tla_pkg::ST_READ;
        end
      end
      tla_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_next = tla_pkg::ST_IDLE;
        end
      end
      tla_pkg::ST_READ: state_next = tla_pkg::ST_SEND;
      tla_pkg::ST_SEND: begin
        if (out_free) begin
          state_next = line_last ? tla_pkg::ST_IDLE : tla_pkg::ST_READ;
        end
      end
      default: state_next = tla_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop        = 1'b0;
    load_echo  = 1'b0;
    load_empty = 1'b0;
    load_line  = 1'b0;
    rd_en      = 1'b0;
    unique case (state)
      tla_pkg::ST_IDLE: begin
        if (q_valid && (!is_byte || out_free)) begin
          pop       = 1'b1;
          load_echo = is_byte;
        end
      end
      tla_pkg::ST_EMPTY: load_empty = out_free;
      tla_pkg::ST_READ:  rd_en = 1'b1;
      tla_pkg::ST_SEND:  load_line = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && is_byte && store_en) begin
      store[fill_count[tla_pkg::IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[rd_ptr[tla_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tla_pkg::ST_IDLE;
      armed      <= 1'b0;
      fill_count <= '0;
      line_limit <= '0;
      line_len   <= '0;
      rd_ptr     <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        if (!is_byte) begin
          // ignore a request while a line is open
          if (!armed && q_cmd.limit != '0) begin
            armed      <= 1'b1;
            line_limit <= q_cmd.limit;
            fill_count <= '0;
          end
        end else if (done) begin
          armed      <= 1'b0;
          fill_count <= '0;
          line_len   <= fill_next;
          rd_ptr     <= '0;
        end else begin
          fill_count <= fill_next;
        end
      end
      if (load_line) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_echo || load_empty || load_line) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_echo) begin
      out_kind   <= tla_pkg::KIND_ECHO;
      out_data   <= q_cmd.data;
      out_length <= '0;
      out_last   <= !done;
    end else if (load_empty) begin
      out_kind   <= tla_pkg::KIND_EMPTY;
      out_data   <= '0;
      out_length <= '0;
      out_last   <= 1'b1;
    end else if (load_line) begin
      out_kind   <= tla_pkg::KIND_LINE;
      out_data   <= rd_data;
      out_length <= line_len;
      out_last   <= line_last;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.kind     = out_kind;
  assign rsp.data_res = out_data;
  assign rsp.length   = out_length;
  assign rsp.last     = out_last;

`ifndef SYNTHESIS
  a_armed_below_limit: assert property (@(posedge clk) disable iff (rst)
    armed |-> (fill_count < line_limit))
    else $error("open line reached its limit without completing");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !armed |-> (fill_count == '0))
    else $error("fill count nonzero while disarmed");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == tla_pkg::ST_READ || state == tla_pkg::ST_SEND) |-> (rd_ptr < line_len))
    else $error("store walk past line length");

  a_walk_holds_queue: assert property (@(posedge clk) disable iff (rst)
    (state != tla_pkg::ST_IDLE) |-> !pop)
    else $error("command taken during line read-out");
`endif

endmodule

// ===== rtl/tty_line_assembler.sv =====
// Terminal line assembler, top level: front end, command queue, back end.
// Depends on tla_pkg, tla_in_if, tla_out_if, tla_front, tla_fifo, tla_back.
//
// Usage:
//   req carries one transaction per item: op 1 arms reception with a line
//   limit (clipped to 32, zero ignored), op 0 delivers a received byte.
//   rsp returns, for each byte, its echo (kind 0), and on line completion
//   either the stored bytes (kind 1, with length) or one empty-line result
//   (kind 2). last marks the final result of each input byte.
// Result path: an echo passes through the command queue and the result
//   register. Line bytes are read out one at a time, each through the READ
//   and SEND states, as set by the registered read port of the line store.
// Throughput: one byte per cycle into the two-entry queue while not full; the
//   back end retires one command per cycle while idle and rsp keeps up.
// Stalls: while rsp.ready is low the result register holds its transaction;
//   the queue keeps accepting until full, then req.ready falls.
// Reset (rst, synchronous): disarms, empties the queue and the result
//   register. The line store is not cleared; no clearing pass is needed.
module tty_line_assembler (
  input logic       clk,
  input logic       rst,
  tla_in_if.sink    req,
  tla_out_if.source rsp
);

  logic          push;
  logic          full;
  logic          pop;
  logic          nonempty;
  tla_pkg::cmd_t push_cmd;
  tla_pkg::cmd_t head;

  tla_front u_front (
    .req      (req),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tla_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  tla_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (nonempty),
    .q_cmd   (head),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for tty_line_assembler: directed and random byte streams with a
// self-contained line-discipline predictor and in-order result checking.
// Depends on tla_pkg, tla_in_if, tla_out_if and the tty_line_assembler RTL.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [5:0] length;
    logic       last;
  } tty_rsp_t;

  logic clk;
  logic rst;

  tla_in_if  req ();
  tla_out_if rsp ();

  tty_line_assembler dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predicted line-discipline state
  logic [7:0]  line_buf [tla_pkg::MAX_LINE];
  int unsigned line_fill;
  int unsigned line_cap;
  bit          line_armed;

  tty_rsp_t owed_results[$];

  bit          tx_idle;
  bit          rx_idle;
  logic        rsp_hold;
  int unsigned rsp_wait;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned reads_sent;
  int unsigned lines_done;
  int unsigned results_seen;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Apply one accepted transaction to the predicted state and queue its results
  task automatic assemble_step(input logic op, input logic [7:0] d, input logic [7:0] lim);
    bit       done;
    tty_rsp_t r;
    done = 1'b0;
    if (op == tla_pkg::OP_READ) begin
      if (!line_armed && lim != 8'd0) begin
        line_cap   = (lim > tla_pkg::MAX_LINE) ? tla_pkg::MAX_LINE : lim;
        line_fill  = 0;
        line_armed = 1'b1;
      end
      return;
    end
    if (line_armed) begin
      if (d == tla_pkg::CH_CR) begin
        if (line_fill < tla_pkg::MAX_LINE) begin
          line_buf[line_fill] = tla_pkg::CH_LF;
          line_fill++;
        end
        done = 1'b1;
      end else if (d == tla_pkg::CH_BS || d == tla_pkg::CH_DEL) begin
        if (line_fill > 0) line_fill--;
      end else if (d >= tla_pkg::CH_FIRST && d <= tla_pkg::CH_LAST) begin
        if (line_fill < tla_pkg::MAX_LINE) begin
          line_buf[line_fill] = d;
          line_fill++;
          if (line_fill >= line_cap) done = 1'b1;
        end else begin
          done = 1'b1;
        end
      end else begin
        done = 1'b1;
      end
    end
    r = {tla_pkg::KIND_ECHO, d, 6'd0, ~done};
    owed_results.push_back(r);
    if (done) begin
      if (line_fill == 0) begin
        r = {tla_pkg::KIND_EMPTY, 8'd0, 6'd0, 1'b1};
        owed_results.push_back(r);
      end else begin
        for (int unsigned i = 0; i < line_fill; i++) begin
          r = {tla_pkg::KIND_LINE, line_buf[i], 6'(line_fill), (i + 1 == line_fill)};
          owed_results.push_back(r);
        end
      end
      line_fill  = 0;
      line_armed = 1'b0;
      lines_done++;
    end
  endtask

  // Offer one transaction and hold it until accepted; valid stays high when
  // the next one follows without a gap
  task automatic send_item(input logic op, input logic [7:0] d, input logic [7:0] lim);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op    <= op;
    req.data  <= d;
    req.limit <= lim;
    do @(posedge clk); while (!req.ready);
    assemble_step(op, d, lim);
    if (op == tla_pkg::OP_READ) reads_sent++;
    else bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] d);
    send_item(tla_pkg::OP_BYTE, d, 8'($urandom));
  endtask

  task automatic send_read(input logic [7:0] lim);
    send_item(tla_pkg::OP_READ, 8'($urandom), lim);
  endtask

  // Drop valid, then hold off until every predicted result has arrived
  task automatic wait_drained(input int unsigned tail);
    req.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_line_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(tla_pkg::CH_FIRST, tla_pkg::CH_LAST));
    if (r < 78) return ($urandom_range(0, 1) != 0) ? tla_pkg::CH_BS : tla_pkg::CH_DEL;
    if (r < 85) return tla_pkg::CH_CR;
    if (r < 92) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic test_disarmed_echo();
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained(4);
  endtask

  task automatic test_read_requests();
    send_read(8'd0);
    send_byte(tla_pkg::CH_LAST);
    send_read(8'd3);
    send_read(8'd200);  // armed already: limit 3 stays
    send_byte(8'h41);
    send_byte(8'h42);
    send_byte(8'h43);
    wait_drained(4);
  endtask

  task automatic test_line_editing();
    send_read(8'd255);
    send_byte(tla_pkg::CH_BS);
    send_byte(tla_pkg::CH_FIRST);
    send_byte(tla_pkg::CH_DEL);
    send_byte(tla_pkg::CH_LAST);
    send_byte(8'h61);
    send_byte(tla_pkg::CH_BS);
    send_byte(tla_pkg::CH_CR);
    wait_drained(4);
  endtask

  task automatic test_line_endings();
    send_read(8'd1);
    send_byte(8'h1B);
    send_read(8'd2);
    send_byte(8'h78);
    send_byte(8'h80);
    send_read(8'd4);
    send_byte(tla_pkg::CH_CR);
    wait_drained(4);
  endtask

  // Stall the result side while a full-length line streams in back to back
  task automatic test_backpressure();
    bit keep_tx;
    keep_tx = tx_idle;
    tx_idle = 1'b0;
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (150) @(posedge clk);
        rsp_hold <= 1'b0;
      end
    join_none
    send_read(8'd32);
    for (int i = 0; i < tla_pkg::MAX_LINE; i++) begin
      send_byte(8'($urandom_range(tla_pkg::CH_FIRST, tla_pkg::CH_LAST)));
    end
    send_byte(8'h5A);
    tx_idle = keep_tx;
    wait_drained(4);
  endtask

  task automatic test_random_lines();
    int unsigned items;
    int unsigned r;
    int unsigned guard;
    logic [7:0]  lim;
    items = 0;
    while (items < 200) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_byte(8'($urandom));
        items++;
      end else if (r == 1) begin
        send_read(8'($urandom));
      end else begin
        if (line_armed) begin
          send_byte(tla_pkg::CH_CR);
          items++;
        end
        r = $urandom_range(0, 19);
        if (r < 14) lim = 8'($urandom_range(1, 12));
        else if (r < 17) lim = 8'($urandom_range(13, 40));
        else if (r < 18) lim = 8'd0;
        else lim = 8'($urandom_range(41, 255));
        send_read(lim);
        if (lim != 8'd0) items++;
        guard = 0;
        while (line_armed) begin
          send_byte((guard < 60) ? pick_line_byte() : tla_pkg::CH_CR);
          guard++;
          items++;
        end
      end
    end
    wait_drained(4);
  endtask

  // Result-side pacing: random wait after each transaction, forced hold-off
  always @(posedge clk) begin : rsp_pace
    int unsigned w;
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_wait  <= 0;
    end else if (rsp_hold) begin
      rsp.ready <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      w = rx_idle ? $urandom_range(0, 8) : 0;
      rsp_wait  <= w;
      rsp.ready <= (w == 0);
    end else if (rsp_wait > 0) begin
      rsp_wait  <= rsp_wait - 1;
      rsp.ready <= (rsp_wait == 1);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : rsp_check
    tty_rsp_t got;
    tty_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.kind, rsp.data_res, rsp.length, rsp.last};
      results_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d data=%h length=%0d last=%0b",
                   got.kind, got.data, got.length, got.last);
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind=%0d data=%h length=%0d last=%0b",
                     want.kind, want.data, want.length, want.last);
            $display("          got      kind=%0d data=%h length=%0d last=%0b",
                     got.kind, got.data, got.length, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, owed_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    line_fill    = 0;
    line_cap     = 0;
    line_armed   = 1'b0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    bytes_sent   = 0;
    reads_sent   = 0;
    lines_done   = 0;
    rsp_hold    <= 1'b0;
    rst         <= 1'b1;
    req.valid   <= 1'b0;
    req.op      <= tla_pkg::OP_BYTE;
    req.data    <= 8'd0;
    req.limit   <= 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disarmed_echo();
    test_read_requests();
    test_line_editing();
    test_line_endings();
    test_backpressure();
    test_random_lines();
    wait_drained(TAIL_CYCLES);

    $display("covered %0d bytes and %0d read requests, %0d lines completed",
             bytes_sent, reads_sent, lines_done);
    $display("checked %0d results in %0d cycles, %0d mismatches, %0d never seen",
             results_seen, cycles, mismatches, owed_results.size());
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tla_pkg.sv
rtl/tla_in_if.sv
rtl/tla_out_if.sv
rtl/tla_front.sv
rtl/tla_fifo.sv
rtl/tla_back.sv
rtl/tty_line_assembler.sv
test/tb_top.sv
